>>> sv/frcf_pkg.sv
// frcf_pkg: shared types, constants and the arctangent table for the roll filter.
// No dependencies; compiled first.
package frcf_pkg;

  localparam int ATAN_LEN = 24;                  // entries in the atan table
  localparam int IDX_W    = 5;                   // table index width
  localparam int INC_W    = 29;                  // rounded gyro increment, Q.16
  localparam int MAG_W    = 17;                  // |accel| incl. 32768
  localparam int XY_W     = 43;                  // CORDIC x/y, 24 frac bits
  localparam int Z_W      = 25;                  // CORDIC angle accumulator
  localparam int Q_DEPTH  = 2;                   // front-to-back queue depth

  localparam logic signed [23:0] DEG90     = 24'sd5898240;
  localparam logic        [16:0] ALPHA_ONE = 17'd65536;
  localparam logic        [16:0] BLEND_RST = 17'd64225;
  localparam logic         [1:0] ADDR_BLEND_WEIGHT = 2'd0;

  typedef enum logic [1:0] {
    TILT_ZERO,
    TILT_POS90,
    TILT_NEG90,
    TILT_CORDIC
  } tilt_kind_t;

  typedef struct packed {
    tilt_kind_t                kind;
    logic                      neg;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic signed [INC_W-1:0]   inc;
  } frcf_entry_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  // atan(2^-i) in Q15.16 degrees, rounded
  function automatic logic [21:0] atan_q16(input logic [IDX_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // clamp to signed 32 bits, flag when clipped
  function automatic sat_t sat32(input logic signed [35:0] v);
    sat_t r;
    if (v > 36'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.hit = 1'b1;
    end else if (v < -36'sd2147483648) begin
      r.val = 32'sh80000000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/frcf_if.sv
// frcf_if: valid/ready channel interfaces for IMU samples and filter results.
// No dependencies.
interface frcf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] gyro_rate;
  logic        [19:0] interval;

  modport source (output valid, accel_x, accel_y, gyro_rate, interval, input ready);
  modport sink   (input valid, accel_x, accel_y, gyro_rate, interval, output ready);
endinterface

interface frcf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fused_angle;
  logic signed [31:0] gyro_angle;
  logic signed [23:0] tilt_angle;
  logic               saturated;

  modport source (output valid, fused_angle, gyro_angle, tilt_angle, saturated, input ready);
  modport sink   (input valid, fused_angle, gyro_angle, tilt_angle, saturated, output ready);
endinterface

>>> sv/frcf_front.sv
// frcf_front: takes IMU samples, classifies the tilt case and forms the gyro increment.
// Depends on frcf_pkg and frcf_sample_if.
module frcf_front import frcf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  frcf_sample_if.sink  in_ch,
  input  logic         q_full,
  output logic         q_push,
  output frcf_entry_t  q_entry
);

  logic               s_valid;
  logic signed [15:0] s_ax;
  logic signed [15:0] s_ay;
  logic signed [15:0] s_gz;
  logic        [19:0] s_dt;

  logic               take;
  logic signed [16:0] ax_e;
  logic signed [16:0] ay_e;
  logic signed [36:0] prod;
  logic signed [36:0] prod_rnd;

  assign in_ch.ready = !s_valid || !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign q_push      = s_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take) begin
      s_valid <= 1'b1;
    end else if (q_push) begin
      s_valid <= 1'b0;
    end
    if (take) begin
      s_ax <= in_ch.accel_x;
      s_ay <= in_ch.accel_y;
      s_gz <= in_ch.gyro_rate;
      s_dt <= in_ch.interval;
    end
  end

  always_comb begin
    ax_e     = {s_ax[15], s_ax};
    ay_e     = {s_ay[15], s_ay};
    prod     = s_gz * $signed({1'b0, s_dt});
    prod_rnd = prod + 37'sd128;

    q_entry.neg   = s_ax[15] ^ s_ay[15];
    q_entry.mag_x = s_ax[15] ? MAG_W'(-ax_e) : MAG_W'(ax_e);
    q_entry.mag_y = s_ay[15] ? MAG_W'(-ay_e) : MAG_W'(ay_e);
    q_entry.inc   = prod_rnd[36:8];   // floor shift by 8

    priority if (s_ay == 16'sd0) begin
      if (s_ax > 16'sd0) begin
        q_entry.kind = TILT_POS90;
      end else if (s_ax < 16'sd0) begin
        q_entry.kind = TILT_NEG90;
      end else begin
        q_entry.kind = TILT_ZERO;
      end
    end else if (s_ax == 16'sd0) begin
      q_entry.kind = TILT_ZERO;
    end else begin
      q_entry.kind = TILT_CORDIC;
    end
  end

endmodule

>>> sv/frcf_queue.sv
// frcf_queue: short FIFO of classified samples between front and back.
// Depends on frcf_pkg.
module frcf_queue import frcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frcf_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output frcf_entry_t head,
  output logic        empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

  frcf_entry_t      slot [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slot[wr_ptr] <= push_entry;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> sv/frcf_back.sv
// frcf_back: iterative CORDIC arctangent, blend multiplies, estimate update, result register.
// Depends on frcf_pkg and frcf_result_if.
module frcf_back import frcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [16:0]   alpha,
  input  logic          q_empty,
  input  frcf_entry_t   q_head,
  output logic          q_pop,
  frcf_result_if.source out_ch
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NSTEP - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_TILT,
    S_MULA,
    S_MULB,
    S_FIN
  } state_t;

  state_t                  state;
  logic [IDX_W-1:0]        cnt;
  tilt_kind_t              kind;
  logic                    neg;
  logic signed [INC_W-1:0] inc;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic signed [23:0]      tilt;
  logic signed [32:0]      sum;
  logic signed [32:0]      gsum;
  logic signed [50:0]      p_a;
  logic signed [41:0]      p_b;
  logic signed [31:0]      fused_est;
  logic signed [31:0]      gyro_est;

  logic                    o_valid;
  logic signed [31:0]      o_fused;
  logic signed [31:0]      o_gyro;
  logic signed [23:0]      o_tilt;
  logic                    o_sat;

  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [Z_W-1:0]   step_ang;
  logic signed [23:0]      zc;
  logic [16:0]             alpha_eff;
  logic [16:0]             beta;
  logic signed [51:0]      blend;
  sat_t                    f_sat;
  sat_t                    g_sat;
  logic                    out_free;
  logic                    commit;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !o_valid || out_ch.ready;
  // result register reloaded this cycle; takes precedence over the drain
  assign commit   = (state == S_FIN) && out_free;

  always_comb begin
    xs        = x >>> cnt;
    ys        = y >>> cnt;
    step_ang  = Z_W'($signed({1'b0, atan_q16(cnt)}));
    alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    beta      = ALPHA_ONE - alpha_eff;
    if (z < 0) begin
      zc = '0;
    end else if (z > Z_W'(DEG90)) begin
      zc = DEG90;
    end else begin
      zc = z[23:0];
    end
    blend = {p_a[50], p_a} + {{10{p_b[41]}}, p_b} + 52'sd32768;
    f_sat = sat32(blend[51:16]);          // floor shift by 16
    g_sat = sat32({{3{gsum[32]}}, gsum});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      o_valid   <= 1'b0;
      fused_est <= '0;
      gyro_est  <= '0;
      cnt       <= '0;
    end else begin
      if (o_valid && out_ch.ready && !commit) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            kind  <= q_head.kind;
            neg   <= q_head.neg;
            inc   <= q_head.inc;
            x     <= XY_W'({q_head.mag_y, 24'd0});
            y     <= XY_W'({q_head.mag_x, 24'd0});
            z     <= '0;
            cnt   <= '0;
            state <= (q_head.kind == TILT_CORDIC) ? S_ITER : S_TILT;
          end
        end
        S_ITER: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + step_ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - step_ang;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_TILT;
          end
        end
        S_TILT: begin
          unique case (kind)
            TILT_ZERO:   tilt <= '0;
            TILT_POS90:  tilt <= DEG90;
            TILT_NEG90:  tilt <= -DEG90;
            TILT_CORDIC: tilt <= neg ? -zc : zc;
            default:     tilt <= '0;
          endcase
          sum   <= {fused_est[31], fused_est} + {{4{inc[INC_W-1]}}, inc};
          gsum  <= {gyro_est[31], gyro_est} + {{4{inc[INC_W-1]}}, inc};
          state <= S_MULA;
        end
        S_MULA: begin
          p_a   <= sum * $signed({1'b0, alpha_eff});
          state <= S_MULB;
        end
        S_MULB: begin
          p_b   <= tilt * $signed({1'b0, beta});
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            fused_est <= f_sat.val;
            gyro_est  <= g_sat.val;
            o_valid   <= 1'b1;
            o_fused   <= f_sat.val;
            o_gyro    <= g_sat.val;
            o_tilt    <= tilt;
            o_sat     <= f_sat.hit || g_sat.hit;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.fused_angle = o_fused;
  assign out_ch.gyro_angle  = o_gyro;
  assign out_ch.tilt_angle  = o_tilt;
  assign out_ch.saturated   = o_sat;

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_tilt <= DEG90) && (o_tilt >= -DEG90))
    else $error("tilt outside +-90 degrees");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_sat) |-> (o_fused == 32'sh7fffffff || o_fused == 32'sh80000000 ||
                            o_gyro == 32'sh7fffffff || o_gyro == 32'sh80000000))
    else $error("saturation flag without a clamped angle");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> (cnt <= LAST_STEP))
    else $error("CORDIC step count overran");

  a_state_kept: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> $stable(fused_est) && $stable(gyro_est))
    else $error("estimate changed outside commit");

endmodule

>>> sv/flatland_roll_complementary_filter.sv
// Roll complementary filter: the back end works on one sample at a time and takes the next
// from the queue only after the current one has committed; the zero/+-90 special cases skip
// the shared CORDIC iteration loop in the back end. Samples keep being taken while
// the queue has room. Reset (rst, synchronous, active high) clears both kept angles, empties
// the queue and result register, and sets blend_weight to 64225.
module flatland_roll_complementary_filter import frcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // APB-style configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // sample in, result out
  frcf_sample_if.sink   in_ch,
  frcf_result_if.source out_ch
);

  // blend weight alpha, Q1.16; values above one act as one in the back end
  logic [16:0] blend_weight;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  frcf_entry_t q_in;
  frcf_entry_t q_head;

  // Register writes complete in the access phase; no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BLEND_WEIGHT) ? {15'd0, blend_weight} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= BLEND_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_BLEND_WEIGHT) begin
      blend_weight <= pwdata[16:0];
    end
  end

  // Front end: one sample register, tilt-case classification and the rounded
  // gyro increment (rate x interval, 24 -> 16 fraction bits).
  frcf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // Queue decouples sample intake from the multi-cycle back end.
  frcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // Back end: CORDIC vectoring for atan(|ax|/|ay|), then the blend and the
  // kept-angle update; the result register lets the next item proceed up to
  // the commit while an earlier result waits for transfer.
  frcf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .alpha   (blend_weight),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> verif/flatland_roll_complementary_filter_tb.sv
// Self-checking testbench for the roll complementary filter: directed table, then random phases.
// Depends on frcf_pkg (sv/frcf_pkg.sv), the channel interfaces (sv/frcf_if.sv) and the top level.
// Results are predicted in-bench and compared field by field in transfer order.
module flatland_roll_complementary_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frcf_pkg::*;

  localparam int CORDIC_STEPS    = 16;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LONG_HOLD       = 400;               // receiver hold-off, cycles
  localparam int SETTLE_CYCLES   = CORDIC_STEPS + 12; // settling wait after the last result
  localparam int DIR_ROWS        = 24;

  localparam longint RIGHT_ANGLE = 64'sd5898240;      // 90 deg in Q15.16
  localparam longint UNITY       = 64'sd65536;        // alpha of one
  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] gz;
    logic        [19:0] dt;
  } imu_sample_t;

  typedef struct {
    logic signed [31:0] fused;
    logic signed [31:0] gyro;
    logic signed [23:0] tilt;
    logic               sat;
  } roll_result_t;

  // directed row: sample plus an optional tilt typed in by hand
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] gz;
    logic        [19:0] dt;
    logic               tilt_fixed;
    logic signed [23:0] tilt;
  } directed_row_t;

  // atan(2^-i) in Q15.16 degrees
  longint atan_step_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Directed part: +-90 and zero special cases, field extremes, alternating bit patterns.
  directed_row_t directed_rows [DIR_ROWS] = '{
    '{16'sd100,    16'sd0,      16'sd0,      20'd0,       1'b1, 24'sd5898240},
    '{-16'sd100,   16'sd0,      16'sd0,      20'd0,       1'b1, -24'sd5898240},
    '{16'sd0,      16'sd0,      16'sd0,      20'd0,       1'b1, 24'sd0},
    '{16'sd0,      16'sd500,    16'sd16,     20'd1048,    1'b1, 24'sd0},
    '{16'sd0,      16'sh8000,   -16'sd16,    20'd1048,    1'b1, 24'sd0},
    '{16'sd32767,  16'sd0,      16'sd32767,  20'd1048575, 1'b1, 24'sd5898240},
    '{16'sh8000,   16'sd0,      16'sh8000,   20'd1048575, 1'b1, -24'sd5898240},
    '{16'sd1,      16'sd0,      16'sd32767,  20'd1,       1'b1, 24'sd5898240},
    '{-16'sd1,     16'sd0,      16'sh8000,   20'd1,       1'b1, -24'sd5898240},
    '{16'sd32767,  16'sd32767,  16'sd0,      20'd1048575, 1'b0, 24'sd0},
    '{16'sh8000,   16'sh8000,   16'sd32767,  20'd0,       1'b0, 24'sd0},
    '{16'sh8000,   16'sd32767,  16'sd1,      20'd1,       1'b0, 24'sd0},
    '{16'sd32767,  16'sh8000,   -16'sd1,     20'd1048575, 1'b0, 24'sd0},
    '{16'sd32767,  16'sd1,      16'sd100,    20'd1000,    1'b0, 24'sd0},
    '{16'sd1,      16'sd32767,  -16'sd100,   20'd1000,    1'b0, 24'sd0},
    '{-16'sd1,     16'sh8000,   16'sd32767,  20'd1048575, 1'b0, 24'sd0},
    '{16'sd1,      16'sd1,      16'sh8000,   20'd1048575, 1'b0, 24'sd0},
    '{-16'sd1,     16'sd1,      16'sd0,      20'd0,       1'b0, 24'sd0},
    '{16'sd12345,  -16'sd23456, 16'sh5555,   20'haaaaa,   1'b0, 24'sd0},
    '{16'shaaaa,   16'sh5555,   16'shaaaa,   20'h55555,   1'b0, 24'sd0},
    '{16'sd0,      16'sd1,      16'sh8000,   20'd1048575, 1'b1, 24'sd0},
    '{16'sd0,      -16'sd1,     16'sd32767,  20'd1048575, 1'b1, 24'sd0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  20'd1048575, 1'b0, 24'sd0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  20'd1048575, 1'b0, 24'sd0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frcf_sample_if sample_ch ();
  frcf_result_if result_ch ();

  flatland_roll_complementary_filter #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (sample_ch),
    .out_ch (result_ch)
  );

  // in-bench copy of the filter state and its one register
  logic        [16:0] blend_model = BLEND_RST;
  logic signed [31:0] fused_est = '0;
  logic signed [31:0] gyro_est = '0;

  roll_result_t pending_results [$];   // predicted results, oldest first

  int send_idle_pct = 0;   // chance per cycle that the sender holds valid low
  int stall_pct     = 0;   // chance per cycle that the receiver holds ready low
  int hold_asks     = 0;   // bumped by the stimulus to ask for a long hold-off
  int fail_count    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Accelerometer roll by CORDIC vectoring on (|ay|, |ax|), clamped to 0..90, signed by ax*ay.
  function automatic longint cordic_tilt(input longint ax, input longint ay);
    longint x, y, z, xs, ys;
    int     steps;
    bit     neg;
    if (ay == 0) return (ax > 0) ? RIGHT_ANGLE : ((ax < 0) ? -RIGHT_ANGLE : 64'sd0);
    if (ax == 0) return 64'sd0;
    neg   = (ax < 0) != (ay < 0);
    x     = ((ay < 0) ? -ay : ay) <<< 24;
    y     = ((ax < 0) ? -ax : ax) <<< 24;
    z     = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;   // arithmetic shift: floor
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += atan_step_deg[i];
      end else begin
        x -= ys;
        y += xs;
        z -= atan_step_deg[i];
      end
    end
    if (z < 0) z = 0;
    if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
    return neg ? -z : z;
  endfunction

  function automatic longint clamp_i32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // One filter step: advances the in-bench state and returns the result it should emit.
  function automatic roll_result_t step_roll_filter(input imu_sample_t s);
    roll_result_t r;
    longint alpha, inc, tilt, g, gc, sum, mix, f, fc;
    alpha = longint'(blend_model);
    if (alpha > UNITY) alpha = UNITY;          // weights above one act as one
    // rate * interval carries 24 fraction bits; round to 16
    inc  = (longint'(s.gz) * longint'(s.dt) + 64'sd128) >>> 8;
    tilt = cordic_tilt(longint'(s.ax), longint'(s.ay));
    g    = longint'(gyro_est) + inc;
    gc   = clamp_i32(g);
    // blend uses the unclamped sum of the previous estimate and the increment
    sum  = longint'(fused_est) + inc;
    mix  = sum * alpha + tilt * (UNITY - alpha);
    f    = (mix + 64'sd32768) >>> 16;
    fc   = clamp_i32(f);
    gyro_est  = gc[31:0];
    fused_est = fc[31:0];
    r.fused = fc[31:0];
    r.gyro  = gc[31:0];
    r.tilt  = tilt[23:0];
    r.sat   = (gc != g) || (fc != f);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(6))
      0:       return 16'sh8000;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // Random sample; spin mode drives sustained near-full-scale rates so the angles clamp.
  function automatic imu_sample_t draw_sample(input int mode, input bit spin_up);
    imu_sample_t s;
    logic [31:0] r1, r2;
    r1   = $urandom;
    r2   = $urandom;
    s.ax = r1[15:0];
    s.ay = r1[31:16];
    s.gz = r2[15:0];
    s.dt = 20'($urandom);
    case (mode)
      4, 5: begin
        // roughly kilohertz sampling, modest rates
        s.gz = 16'(int'($urandom_range(4000)) - 2000);
        s.dt = 20'($urandom_range(1200, 900));
      end
      6: begin
        s.ax = corner_value();
        s.ay = corner_value();
      end
      7: begin
        // tiny vectors, zero axes likely
        s.ax = 16'(int'($urandom_range(6)) - 3);
        s.ay = 16'(int'($urandom_range(6)) - 3);
        s.dt = 20'($urandom_range(3));
      end
      9: begin
        s.gz = spin_up ? 16'($urandom_range(32767, 30000))
                       : 16'(-int'($urandom_range(32768, 30000)));
        s.dt = 20'($urandom_range(1048575, 1000000));
      end
      default: ;
    endcase
    return s;
  endfunction

  // Offer one sample until it transfers; the expectation is formed at the transfer edge.
  task automatic offer_sample(input imu_sample_t s, input logic tilt_fixed,
                              input logic signed [23:0] tilt_val);
    roll_result_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.accel_x   <= s.ax;
    sample_ch.accel_y   <= s.ay;
    sample_ch.gyro_rate <= s.gz;
    sample_ch.interval  <= s.dt;
    do @(posedge clk); while (!sample_ch.ready);
    want = step_roll_filter(s);
    if (tilt_fixed) want.tilt = tilt_val;
    pending_results.push_back(want);
  endtask

  // APB setup + access, then psel low before returning so back-to-back calls never clash on psel.
  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BLEND_WEIGHT;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_blend_readback();
    logic [31:0] rd;
    apb_transfer(1'b0, 32'd0, rd);
    if (rd !== {15'd0, blend_model}) begin
      $error("blend_weight readback: expected %0d, got %0d", blend_model, rd);
      fail_count++;
    end
  endtask

  task automatic set_blend_weight(input logic [31:0] wdata);
    logic [31:0] rd;
    apb_transfer(1'b1, wdata, rd);
    blend_model = wdata[16:0];   // only 17 bits are kept
    verify_blend_readback();
  endtask

  // Wait until every predicted result has come back, then let the pipe settle.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, long hold-off on request, and checking
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int           hold_left;
    int           hold_seen;
    roll_result_t want;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.fused_angle !== want.fused) begin
            $error("fused_angle: expected %0d, got %0d", want.fused, result_ch.fused_angle);
            fail_count++;
          end
          if (result_ch.gyro_angle !== want.gyro) begin
            $error("gyro_angle: expected %0d, got %0d", want.gyro, result_ch.gyro_angle);
            fail_count++;
          end
          if (result_ch.tilt_angle !== want.tilt) begin
            $error("tilt_angle: expected %0d, got %0d", want.tilt, result_ch.tilt_angle);
            fail_count++;
          end
          if (result_ch.saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, result_ch.saturated);
            fail_count++;
          end
        end
      end
      // a fresh request starts a long hold-off, counted here
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    imu_sample_t   s;
    directed_row_t row;
    logic [31:0]   wdata;
    int            sent;
    int            mode;
    int            burst;
    bit            spin_up;

    sample_ch.valid     <= 1'b0;
    sample_ch.accel_x   <= '0;
    sample_ch.accel_y   <= '0;
    sample_ch.gyro_rate <= '0;
    sample_ch.interval  <= '0;

    // single reset at the start
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register must come out of reset at its documented value
    verify_blend_readback();

    // Directed table at the reset weight, no idling on either side.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row  = directed_rows[i];
      s.ax = row.ax;
      s.ay = row.ay;
      s.gz = row.gz;
      s.dt = row.dt;
      offer_sample(s, row.tilt_fixed, row.tilt);
    end
    sample_ch.valid <= 1'b0;
    drain_results();

    // Random phases: each with its own weight and handshake pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       wdata = 32'd0;
        1:       wdata = 32'd65536;             // exactly one
        2:       wdata = 32'd131071;            // above one, must act as one
        3:       wdata = $urandom;              // upper bus bits junk
        4:       wdata = 32'd1;
        5:       wdata = {15'd0, BLEND_RST};
        6:       wdata = 32'd65535;
        default: wdata = $urandom_range(65536);
      endcase
      set_blend_weight(wdata);

      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase

      // back-pressure burst: receiver holds off while the sender keeps offering
      if (phase % 4 == 0) hold_asks++;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        mode    = $urandom_range(9);
        spin_up = $urandom_range(1);
        burst   = (mode == 9) ? $urandom_range(40, 18) : $urandom_range(30, 1);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          s = draw_sample(mode, spin_up);
          offer_sample(s, 1'b0, 24'sd0);
          sent++;
        end
      end
      sample_ch.valid <= 1'b0;
      drain_results();
    end

    // drain_results already let the pipe settle once the last result landed
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
